>>> rtl/pdtc_pkg.sv
`default_nettype none

package pdtc_pkg;

  // field widths of the data words
  localparam int MODE_W   = 2;
  localparam int ML_W     = 10;
  localparam int MOIST_W  = 12;
  localparam int DLEN_W   = 28;

  // configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 20;
  localparam int FLOW_W    = 16;
  localparam int CHECK_W   = 20;
  localparam int KICK_W    = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_RATE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DOSE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_DOSE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_IVL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KICK_LEN     = 3'd6;

  // register reset values
  localparam logic [FLOW_W-1:0]  FLOW_RST      = 16'd2048;
  localparam logic [ML_W-1:0]    MAX_DOSE_RST  = 10'd150;
  localparam logic [ML_W-1:0]    AUTO_DOSE_RST = 10'd50;
  localparam logic [MOIST_W-1:0] THRESH_RST    = 12'd2300;
  localparam logic [CHECK_W-1:0] CHECK_RST     = 20'd10000;
  localparam logic [KICK_W-1:0]  KICK_RST      = 16'd500;

  // dose length = ml * 1000 * 256 / flow_q8; numerator fits in 28 bits
  localparam int MS_PER_S   = 1000;
  localparam int PROD_W     = 20;
  localparam int NUM_W      = 28;
  localparam int CNT_W      = $clog2(NUM_W);
  localparam logic [CHECK_W-1:0] CHECK_MAX = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    PH_OFF  = 2'd0,
    PH_KICK = 2'd1,
    PH_RUN  = 2'd2
  } phase_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_CAPPED  = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ML_W-1:0]    dose_ml;
    logic [MOIST_W-1:0] moisture;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        pump_drive;
    logic              busy_res;
    logic [1:0]        status;
    logic              dose_done;
    logic [DLEN_W-1:0] dose_length_ms;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/pump_dose_timer_controller.sv
// pump dose timer controller
//
// cmd channel (cmd_valid/cmd_ready/cmd) carries one word per item: a 1 ms
// tick with a moisture sample, a start with a dose in mL, or a stop.
// res channel (res_valid/res_ready/res) returns exactly one word per item:
// pump drive, busy flag, status, done flag and the dose length in ms.
// cfg port (cfg_we/cfg_index/cfg_data) writes one register per cycle; the
// user must write it only while the block is idle; nothing enforces it.
//
// sequence: a word is taken only in the idle state. ticks, stops, rejected
// starts and unknown modes pass through capture and execute. a start that
// runs, including an auto start on a tick, passes through capture, setup
// with the mL x 1000 product, 28 steps of the shared one bit per cycle
// restoring divider, and a final commit step.
// the result sits in an output register; the next word may be captured
// while it waits, and a start may run its divider meanwhile, but the pump
// and timer state commit only once the output register is free, so a
// stalled receiver only stalls the block.
// reset (rst, synchronous) sets state and config registers to defaults,
// stops the pump, clears all timers and empties the output register.
`default_nettype none

module pump_dose_timer_controller
  import pdtc_pkg::*;
#(
  parameter int TIMER_BITS = 28
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire cmd_t                 cmd,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output res_t                      res,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  // common width for saturating the quotient to the timer range
  localparam int CW = (TIMER_BITS > NUM_W) ? TIMER_BITS : NUM_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  // configuration registers
  logic               auto_enable;
  logic [FLOW_W-1:0]  flow_rate_q8;
  logic [ML_W-1:0]    max_dose_ml;
  logic [ML_W-1:0]    auto_dose_ml;
  logic [MOIST_W-1:0] moisture_threshold;
  logic [CHECK_W-1:0] check_interval_ms;
  logic [KICK_W-1:0]  kick_length_ms;

  // controller state
  state_t                state, state_next;
  cmd_t                  cmd_q;
  logic                  dosing, dosing_next;
  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] elapsed, elapsed_next;
  logic [TIMER_BITS-1:0] dose_length, dose_length_next;
  logic [CHECK_W-1:0]    since_check, since_check_next;

  // divider and pending start
  logic [NUM_W-1:0]  quo, quo_next;
  logic [FLOW_W-1:0] rem, rem_next;
  logic [CNT_W-1:0]  div_cnt, div_cnt_next;
  logic [1:0]        start_status, start_status_next;
  logic              from_tick, from_tick_next;

  // output register
  logic res_valid_next;
  res_t res_next;

  // combinational helpers
  logic                  slot_free;
  logic [CHECK_W-1:0]    sc_inc;
  logic [TIMER_BITS-1:0] el_inc;
  logic                  auto_fire;
  logic                  dry;
  logic [ML_W-1:0]       req_ml;
  logic [ML_W-1:0]       ml_eff;
  logic                  capped;
  logic [PROD_W-1:0]     prod;
  logic [FLOW_W:0]       rem_sh;
  logic                  fits;
  logic [CW-1:0]         q_ext;
  logic [TIMER_BITS-1:0] len;

  assign cmd_ready = (state == S_IDLE);
  assign slot_free = !res_valid || res_ready;

  assign sc_inc = (since_check != CHECK_MAX) ? since_check + 1'b1 : since_check;
  assign el_inc = (dosing && elapsed != TIMER_MAX) ? elapsed + 1'b1 : elapsed;
  assign auto_fire = !dosing && auto_enable && (sc_inc > check_interval_ms);
  assign dry = cmd_q.moisture > moisture_threshold;

  // dose request, capping and the mL x 1000 product for the divider
  assign req_ml = (cmd_q.mode == MODE_TICK) ? auto_dose_ml : cmd_q.dose_ml;
  assign capped = req_ml > max_dose_ml;
  assign ml_eff = capped ? max_dose_ml : req_ml;
  assign prod   = PROD_W'(ml_eff) * PROD_W'(MS_PER_S);

  // one restoring divide step
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, flow_rate_q8};

  // quotient saturated to the timer range, zero flow gives the maximum
  assign q_ext = CW'(quo);
  assign len = (flow_rate_q8 == '0 || q_ext > CW'(TIMER_MAX)) ? TIMER_MAX
             : TIMER_BITS'(q_ext);

  always_comb begin
    state_next        = state;
    dosing_next       = dosing;
    phase_next        = phase;
    elapsed_next      = elapsed;
    dose_length_next  = dose_length;
    since_check_next  = since_check;
    quo_next          = quo;
    rem_next          = rem;
    div_cnt_next      = div_cnt;
    start_status_next = start_status;
    from_tick_next    = from_tick;
    res_valid_next    = res_valid && !res_ready;
    res_next          = res;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        res_next.status    = ST_OK;
        res_next.dose_done = 1'b0;
        unique case (cmd_q.mode)
          MODE_TICK: begin
            if (auto_fire && dry && auto_dose_ml != '0) begin
              // automatic start: launch the divider
              since_check_next  = '0;
              from_tick_next    = 1'b1;
              start_status_next = capped ? ST_CAPPED : ST_OK;
              quo_next          = {prod, 8'd0};
              rem_next          = '0;
              div_cnt_next      = '0;
              state_next        = S_DIV;
            end else if (slot_free) begin
              since_check_next = auto_fire ? '0 : sc_inc;
              elapsed_next     = el_inc;
              if (auto_fire && dry) begin
                res_next.status = ST_INVALID;
              end
              if (dosing) begin
                if (phase == PH_KICK && el_inc >= TIMER_BITS'(kick_length_ms)) begin
                  phase_next = PH_RUN;
                end
                if (el_inc >= dose_length) begin
                  phase_next         = PH_OFF;
                  dosing_next        = 1'b0;
                  res_next.dose_done = 1'b1;
                end
              end
              res_valid_next = 1'b1;
              state_next     = S_IDLE;
            end
          end
          MODE_START: begin
            if (!dosing && cmd_q.dose_ml != '0) begin
              from_tick_next    = 1'b0;
              start_status_next = capped ? ST_CAPPED : ST_OK;
              quo_next          = {prod, 8'd0};
              rem_next          = '0;
              div_cnt_next      = '0;
              state_next        = S_DIV;
            end else if (slot_free) begin
              res_next.status = dosing ? ST_BUSY : ST_INVALID;
              res_valid_next  = 1'b1;
              state_next      = S_IDLE;
            end
          end
          MODE_STOP: begin
            if (slot_free) begin
              phase_next     = PH_OFF;
              dosing_next    = 1'b0;
              res_valid_next = 1'b1;
              state_next     = S_IDLE;
            end
          end
          default: begin
            // unused mode: no operation
            if (slot_free) begin
              res_valid_next = 1'b1;
              state_next     = S_IDLE;
            end
          end
        endcase
        res_next.pump_drive     = phase_next;
        res_next.busy_res       = dosing_next;
        res_next.dose_length_ms = DLEN_W'(dose_length_next);
      end

      S_DIV: begin
        quo_next = {quo[NUM_W-2:0], fits};
        rem_next = fits ? FLOW_W'(rem_sh - {1'b0, flow_rate_q8}) : rem_sh[FLOW_W-1:0];
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == CNT_W'(NUM_W - 1)) begin
          state_next = S_FIN;
        end
      end

      S_FIN: begin
        res_next.status    = start_status;
        res_next.dose_done = 1'b0;
        if (slot_free) begin
          dose_length_next = len;
          elapsed_next     = '0;
          dosing_next      = 1'b1;
          phase_next       = PH_KICK;
          // a tick start gets the pump control pass at zero elapsed time
          if (from_tick) begin
            if (kick_length_ms == '0) begin
              phase_next = PH_RUN;
            end
            if (len == '0) begin
              phase_next         = PH_OFF;
              dosing_next        = 1'b0;
              res_next.dose_done = 1'b1;
            end
          end
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
        res_next.pump_drive     = phase_next;
        res_next.busy_res       = dosing_next;
        res_next.dose_length_ms = DLEN_W'(dose_length_next);
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      dosing      <= 1'b0;
      phase       <= PH_OFF;
      elapsed     <= '0;
      dose_length <= '0;
      since_check <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      dosing      <= dosing_next;
      phase       <= phase_next;
      elapsed     <= elapsed_next;
      dose_length <= dose_length_next;
      since_check <= since_check_next;
      res_valid   <= res_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_q <= cmd;
    end
    quo          <= quo_next;
    rem          <= rem_next;
    div_cnt      <= div_cnt_next;
    start_status <= start_status_next;
    from_tick    <= from_tick_next;
    // a waiting output word keeps its payload
    if (slot_free) begin
      res <= res_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_enable        <= 1'b0;
      flow_rate_q8       <= FLOW_RST;
      max_dose_ml        <= MAX_DOSE_RST;
      auto_dose_ml       <= AUTO_DOSE_RST;
      moisture_threshold <= THRESH_RST;
      check_interval_ms  <= CHECK_RST;
      kick_length_ms     <= KICK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUTO_ENABLE: auto_enable        <= cfg_data[0];
        CFG_FLOW_RATE:   flow_rate_q8       <= cfg_data[FLOW_W-1:0];
        CFG_MAX_DOSE:    max_dose_ml        <= cfg_data[ML_W-1:0];
        CFG_AUTO_DOSE:   auto_dose_ml       <= cfg_data[ML_W-1:0];
        CFG_THRESHOLD:   moisture_threshold <= cfg_data[MOIST_W-1:0];
        CFG_CHECK_IVL:   check_interval_ms  <= cfg_data[CHECK_W-1:0];
        CFG_KICK_LEN:    kick_length_ms     <= cfg_data[KICK_W-1:0];
        default: ;
      endcase
    end
  end

  // pump runs exactly while a dose is in progress
  a_phase_dosing: assert property (@(posedge clk) disable iff (rst)
    dosing == (phase != PH_OFF))
    else $error("pump phase and dosing flag disagree");

  // a completed dose is never reported as still busy
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.dose_done && res.busy_res))
    else $error("dose done while busy");

  // divider step count stays within the quotient width
  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt < CNT_W'(NUM_W)))
    else $error("divider overran");

  // a final commit always loads the output register
  a_fin_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && slot_free) |=> (res_valid && state == S_IDLE))
    else $error("start result lost");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
  import pdtc_pkg::*;

  localparam int TIMER_BITS = 28;
  localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

  // mode code that the block must treat as a no-op
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // drain time: long enough for a start that runs to finish, with margin
  localparam int DRAIN_CYCLES = 40;
  // long receiver hold-off so the block fills and stalls its input
  localparam int HOLD_CYCLES  = 300;
  // cycles without any accepted word before the run is declared hung
  localparam int QUIET_LIMIT  = 3000;
  localparam int MAX_SHOWN    = 10;

  logic                 clk;
  logic                 rst;
  logic                 cmd_valid;
  logic                 cmd_ready;
  cmd_t                 cmd_word;
  logic                 res_valid;
  logic                 res_ready;
  res_t                 res_word;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // shared test controls
  bit idle_on;
  bit hold_req;
  int errors;
  int quiet_cycles;

  // results predicted for accepted words, oldest first
  res_t pending_res[$];

  // predictor copy of the registers
  logic              c_auto;
  logic [FLOW_W-1:0] c_flow;
  logic [ML_W-1:0]   c_max;
  logic [ML_W-1:0]   c_auto_dose;
  logic [MOIST_W-1:0] c_thresh;
  logic [CHECK_W-1:0] c_check;
  logic [KICK_W-1:0] c_kick;

  // predictor copy of the dosing state
  logic               m_dosing;
  phase_t             m_phase;
  logic [31:0]        m_elapsed;
  logic [31:0]        m_dlen;
  logic [CHECK_W-1:0] m_since;

  pump_dose_timer_controller #(
    .TIMER_BITS(TIMER_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // dosing predictor
  // ---------------------------------------------------------------------

  task automatic dose_state_reset();
    c_auto      = 1'b0;
    c_flow      = FLOW_RST;
    c_max       = MAX_DOSE_RST;
    c_auto_dose = AUTO_DOSE_RST;
    c_thresh    = THRESH_RST;
    c_check     = CHECK_RST;
    c_kick      = KICK_RST;
    m_dosing    = 1'b0;
    m_phase     = PH_OFF;
    m_elapsed   = '0;
    m_dlen      = '0;
    m_since     = '0;
  endtask

  // try to start a dose; returns the start status
  function automatic logic [1:0] dose_begin(input logic [ML_W-1:0] ml_req);
    logic [ML_W-1:0] ml;
    logic [1:0]      st;
    logic [63:0]     len;
    ml = ml_req;
    st = ST_OK;
    // busy check wins over the zero check
    if (m_dosing) return ST_BUSY;
    if (ml == '0) return ST_INVALID;
    if (ml > c_max) begin
      ml = c_max;
      st = ST_CAPPED;
    end
    // ms = ml * 1000 / (flow / 256); zero flow gives the maximum length
    if (c_flow == '0) begin
      len = 64'(TIMER_MAX);
    end else begin
      len = (64'(ml) * 64'd256000) / 64'(c_flow);
      if (len > 64'(TIMER_MAX)) len = 64'(TIMER_MAX);
    end
    m_dlen    = len[31:0];
    m_elapsed = '0;
    m_phase   = PH_KICK;
    m_dosing  = 1'b1;
    return st;
  endfunction

  // advance the predictor by one word and return the expected result
  function automatic res_t dose_predict(input cmd_t w);
    res_t       r;
    logic [1:0] st;
    logic       done;
    st   = ST_OK;
    done = 1'b0;
    case (w.mode)
      MODE_TICK: begin
        if (m_since < CHECK_MAX) m_since = m_since + 1'b1;
        if (m_dosing && m_elapsed < TIMER_MAX) m_elapsed = m_elapsed + 1;
        // periodic moisture check only while idle
        if (!m_dosing && c_auto && m_since > c_check) begin
          m_since = '0;
          if (w.moisture > c_thresh) st = dose_begin(c_auto_dose);
        end
        if (m_dosing) begin
          if (m_phase == PH_KICK && m_elapsed >= 32'(c_kick)) m_phase = PH_RUN;
          if (m_elapsed >= m_dlen) begin
            m_phase  = PH_OFF;
            m_dosing = 1'b0;
            done     = 1'b1;
          end
        end
      end
      MODE_START: begin
        st = dose_begin(w.dose_ml);
      end
      MODE_STOP: begin
        // ends the dose quietly, length is kept
        m_phase  = PH_OFF;
        m_dosing = 1'b0;
      end
      default: begin
      end
    endcase
    r.pump_drive     = m_phase;
    r.busy_res       = m_dosing;
    r.status         = st;
    r.dose_done      = done;
    r.dose_length_ms = m_dlen[DLEN_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------

  function automatic cmd_t word_of(input logic [MODE_W-1:0] md, input int ml, input int moist);
    cmd_t w;
    w.mode     = md;
    w.dose_ml  = ML_W'(ml);
    w.moisture = MOIST_W'(moist);
    return w;
  endfunction

  // offer one word, hold it until taken, then predict its result
  task automatic send_word(input cmd_t w);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word  <= w;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    pending_res.push_back(dose_predict(w));
  endtask

  // drop valid, wait for every result, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  // writes every register; only called with the block idle
  task automatic load_config(input logic en, input int flow, input int maxd, input int autod,
                             input int thr, input int chk, input int kick);
    settle();
    cfg_put(CFG_AUTO_ENABLE, CFG_W'(en));
    cfg_put(CFG_FLOW_RATE,   CFG_W'(FLOW_W'(flow)));
    cfg_put(CFG_MAX_DOSE,    CFG_W'(ML_W'(maxd)));
    cfg_put(CFG_AUTO_DOSE,   CFG_W'(ML_W'(autod)));
    cfg_put(CFG_THRESHOLD,   CFG_W'(MOIST_W'(thr)));
    cfg_put(CFG_CHECK_IVL,   CFG_W'(CHECK_W'(chk)));
    cfg_put(CFG_KICK_LEN,    CFG_W'(KICK_W'(kick)));
    @(negedge clk);
    cfg_we <= 1'b0;
    c_auto      = en;
    c_flow      = FLOW_W'(flow);
    c_max       = ML_W'(maxd);
    c_auto_dose = ML_W'(autod);
    c_thresh    = MOIST_W'(thr);
    c_check     = CHECK_W'(chk);
    c_kick      = KICK_W'(kick);
  endtask

  // mostly ticks, some starts around the cap, stops and no-op words
  function automatic cmd_t rand_word();
    cmd_t w;
    int   pick;
    int   hi;
    w.dose_ml  = ML_W'($urandom);
    w.moisture = MOIST_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      w.mode = MODE_TICK;
    end else if (pick < 91) begin
      w.mode = MODE_START;
      hi = int'(c_max) + 3;
      if (hi > 1023) hi = 1023;
      case ($urandom_range(0, 6))
        0:       w.dose_ml = '0;
        1:       ;
        default: w.dose_ml = ML_W'($urandom_range(1, hi));
      endcase
    end else if (pick < 97) begin
      w.mode = MODE_STOP;
    end else begin
      w.mode = MODE_UNUSED;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------
  // receiver side: random stall bursts, one long hold on request
  // ---------------------------------------------------------------------

  initial begin
    res_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------

  task automatic note_mismatch(input string what, input res_t exp, input res_t got);
    if (errors < MAX_SHOWN)
      $display("%0t %s: exp drive %0d busy %0d status %0d done %0d len %0d, got drive %0d busy %0d status %0d done %0d len %0d",
               $realtime, what, exp.pump_drive, exp.busy_res, exp.status, exp.dose_done,
               exp.dose_length_ms, got.pump_drive, got.busy_res, got.status, got.dose_done,
               got.dose_length_ms);
    errors++;
  endtask

  always @(posedge clk) begin
    res_t exp;
    if (!rst && res_valid && res_ready) begin
      if (pending_res.size() == 0) begin
        note_mismatch("word with nothing expected", '0, res_word);
      end else begin
        exp = pending_res.pop_front();
        if (res_word.pump_drive !== exp.pump_drive || res_word.busy_res !== exp.busy_res ||
            res_word.status !== exp.status || res_word.dose_done !== exp.dose_done ||
            res_word.dose_length_ms !== exp.dose_length_ms)
          note_mismatch("result mismatch", exp, res_word);
      end
    end
  end

  // hang detector: nothing accepted on either channel for too long
  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // reset register values: rejects, busy priority, cap, stop, no-op mode
  task automatic test_reset_defaults();
    send_word(word_of(MODE_TICK, 0, 4095));
    send_word(word_of(MODE_UNUSED, 1023, 4095));
    send_word(word_of(MODE_START, 0, 0));
    send_word(word_of(MODE_START, 1, 0));
    send_word(word_of(MODE_START, 5, 0));
    send_word(word_of(MODE_START, 0, 0));
    send_word(word_of(MODE_TICK, 0, 0));
    send_word(word_of(MODE_STOP, 0, 0));
    send_word(word_of(MODE_START, 1023, 0));
    send_word(word_of(MODE_STOP, 1023, 4095));
  endtask

  // zero flow: the dose length saturates and a stop ends it
  task automatic test_zero_flow();
    load_config(1'b0, 0, 1023, 50, 2300, 10000, 500);
    send_word(word_of(MODE_START, 7, 0));
    send_word(word_of(MODE_TICK, 0, 0));
    send_word(word_of(MODE_STOP, 0, 0));
  endtask

  // zero cap: capped dose of zero length finishes on the next tick
  task automatic test_zero_cap();
    load_config(1'b0, 1, 0, 50, 2300, 10000, 0);
    send_word(word_of(MODE_START, 5, 0));
    send_word(word_of(MODE_TICK, 0, 0));
  endtask

  // slowest flow with the largest dose and the longest kick
  task automatic test_long_dose();
    load_config(1'b0, 1, 1023, 1023, 4095, 10000, 65535);
    send_word(word_of(MODE_START, 1023, 0));
    send_word(word_of(MODE_TICK, 0, 0));
    send_word(word_of(MODE_STOP, 0, 0));
  endtask

  // auto check: strict threshold compare, kick to run, completion
  task automatic test_auto_check();
    load_config(1'b1, 65535, 1023, 1, 0, 0, 2);
    send_word(word_of(MODE_TICK, 0, 0));
    send_word(word_of(MODE_TICK, 0, 1));
    send_word(word_of(MODE_TICK, 0, 0));
    send_word(word_of(MODE_TICK, 0, 0));
    send_word(word_of(MODE_TICK, 0, 0));
  endtask

  // auto dose of zero is rejected; maximal interval never fires
  task automatic test_auto_edges();
    load_config(1'b1, 65535, 1023, 0, 0, 0, 0);
    send_word(word_of(MODE_TICK, 0, 4095));
    load_config(1'b1, 65535, 1023, 5, 0, 1048575, 0);
    send_word(word_of(MODE_TICK, 0, 4095));
    send_word(word_of(MODE_TICK, 0, 4095));
  endtask

  // random phases, each with its own register setting
  task automatic test_random_mix();
    logic en;
    int   flow;
    int   maxd;
    int   autod;
    int   thr;
    int   chk;
    for (int p = 0; p < 8; p++) begin
      en    = (p % 3 != 2);
      flow  = (p == 2) ? 65535 : $urandom_range(32768, 65535);
      maxd  = (p == 3) ? 1023 : $urandom_range(1, 12);
      autod = (p == 4) ? 1023 : (p == 5) ? 0 : $urandom_range(1, 12);
      thr   = (p == 0) ? 0 : (p == 1) ? 4095 : $urandom_range(0, 4095);
      chk   = (p == 6) ? 0 : $urandom_range(1, 30);
      load_config(en, flow, maxd, autod, thr, chk, $urandom_range(0, 40));
      repeat (190) send_word(rand_word());
    end
  endtask

  // receiver holds off while words keep coming, so the input stalls
  task automatic test_backpressure();
    load_config(1'b1, 65535, 6, 6, 1000, 3, 1);
    idle_on  = 1'b0;
    hold_req = 1'b1;
    repeat (60) send_word(rand_word());
    idle_on = 1'b1;
  endtask

  // last stretch back to back on both sides
  task automatic test_no_idle();
    load_config(1'b1, $urandom_range(40000, 65535), 8, 4, 2000, 5, 3);
    idle_on = 1'b0;
    repeat (200) send_word(rand_word());
  endtask

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd_word  = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    errors    = 0;
    dose_state_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_zero_flow();
    test_zero_cap();
    test_long_dose();
    test_auto_check();
    test_auto_edges();
    test_random_mix();
    test_backpressure();
    test_no_idle();
    settle();

    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> pump_dose_timer_controller.f
rtl/pdtc_pkg.sv
rtl/pump_dose_timer_controller.sv
tb/tb_top.sv
